// ===== hdl/dopq_pkg.sv =====
// shared types, codes and field positions of the dual-order priority queue
package dopq_pkg;

    // request modes
    localparam logic [1:0] MODE_ENQ    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_OLDEST = 2'd2;
    localparam logic [1:0] MODE_BEST   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // field widths fixed by the stream format
    localparam int MODE_BITS     = 2;
    localparam int PORT_TAG_BITS = 16;
    localparam int PRIO_BITS     = 64;
    localparam int STATUS_BITS   = 2;

    // input tdata layout, lowest bit first
    localparam int IN_MODE_LSB  = 0;
    localparam int IN_TAG_LSB   = IN_MODE_LSB + MODE_BITS;
    localparam int IN_PRIO_LSB  = IN_TAG_LSB + PORT_TAG_BITS;
    localparam int IN_USED_BITS = IN_PRIO_LSB + PRIO_BITS;
    localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_FOUND_LSB  = 0;
    localparam int OUT_TAG_LSB    = OUT_FOUND_LSB + 1;
    localparam int OUT_PRIO_LSB   = OUT_TAG_LSB + PORT_TAG_BITS;
    localparam int OUT_STATUS_LSB = OUT_PRIO_LSB + PRIO_BITS;
    localparam int OUT_USED_BITS  = OUT_STATUS_LSB + STATUS_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;

    // control part of the request wave that travels down the cell chain
    typedef struct packed {
        logic                 active;
        logic [MODE_BITS-1:0] mode;
        logic                 hit;
        logic                 placed;
        logic                 best_ok;
    } wave_ctl_t;

endpackage

// ===== hdl/dopq_cell.sv =====
// one queue cell: holds an entry and handles the request wave as it passes
module dopq_cell #(
    parameter int TW = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dopq_pkg::wave_ctl_t                  ctl_in,
    input  logic [TW-1:0]                        tag_in,
    input  logic signed [dopq_pkg::PRIO_BITS-1:0] prio_in,
    input  logic [TW-1:0]                        best_tag_in,
    input  logic signed [dopq_pkg::PRIO_BITS-1:0] best_prio_in,
    input  logic                                 nb_valid,
    input  logic [TW-1:0]                        nb_tag,
    input  logic signed [dopq_pkg::PRIO_BITS-1:0] nb_prio,
    output dopq_pkg::wave_ctl_t                  ctl_out,
    output logic [TW-1:0]                        tag_out,
    output logic signed [dopq_pkg::PRIO_BITS-1:0] prio_out,
    output logic [TW-1:0]                        best_tag_out,
    output logic signed [dopq_pkg::PRIO_BITS-1:0] best_prio_out,
    output logic                                 own_valid,
    output logic [TW-1:0]                        own_tag,
    output logic signed [dopq_pkg::PRIO_BITS-1:0] own_prio
);
    import dopq_pkg::*;

    logic                        valid_reg, valid_next;
    logic [TW-1:0]               tag_reg, tag_next;
    logic signed [PRIO_BITS-1:0] prio_reg, prio_next;

    wave_ctl_t                   wctl_reg, wctl_next;
    logic [TW-1:0]               wtag_reg;
    logic signed [PRIO_BITS-1:0] wprio_reg;
    logic [TW-1:0]               wbtag_reg, wbtag_next;
    logic signed [PRIO_BITS-1:0] wbprio_reg, wbprio_next;

    logic match;

    assign match = valid_reg && (tag_reg == tag_in);

    // entry update and wave hand-off
    always_comb begin
        valid_next  = valid_reg;
        tag_next    = tag_reg;
        prio_next   = prio_reg;
        wctl_next   = ctl_in;
        wbtag_next  = best_tag_in;
        wbprio_next = best_prio_in;
        if (ctl_in.active) begin
            unique case (ctl_in.mode)
                MODE_ENQ: begin
                    // first free cell comes after every stored entry
                    if (match) begin
                        wctl_next.hit = 1'b1;
                    end else if (!valid_reg && !ctl_in.hit && !ctl_in.placed) begin
                        valid_next       = 1'b1;
                        tag_next         = tag_in;
                        prio_next        = prio_in;
                        wctl_next.placed = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    // from the matching cell on, take the neighbor's entry
                    if (ctl_in.hit || match) begin
                        valid_next    = nb_valid;
                        tag_next      = nb_tag;
                        prio_next     = nb_prio;
                        wctl_next.hit = 1'b1;
                    end
                end
                MODE_OLDEST: begin
                    if (valid_reg && !ctl_in.best_ok) begin
                        wctl_next.best_ok = 1'b1;
                        wbtag_next        = tag_reg;
                        wbprio_next       = prio_reg;
                    end
                end
                MODE_BEST: begin
                    // strict less keeps the earliest arrival on ties
                    if (valid_reg && (!ctl_in.best_ok || prio_reg < best_prio_in)) begin
                        wctl_next.best_ok = 1'b1;
                        wbtag_next        = tag_reg;
                        wbprio_next       = prio_reg;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            wctl_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            wctl_reg  <= wctl_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        tag_reg    <= tag_next;
        prio_reg   <= prio_next;
        wtag_reg   <= tag_in;
        wprio_reg  <= prio_in;
        wbtag_reg  <= wbtag_next;
        wbprio_reg <= wbprio_next;
    end

    assign ctl_out       = wctl_reg;
    assign tag_out       = wtag_reg;
    assign prio_out      = wprio_reg;
    assign best_tag_out  = wbtag_reg;
    assign best_prio_out = wbprio_reg;
    assign own_valid     = valid_reg;
    assign own_tag       = tag_reg;
    assign own_prio      = prio_reg;

endmodule

// ===== hdl/dual_order_priority_queue.sv =====
// top level: cell chain of the dual-order priority queue with its stream ports
//
// Holds up to QUEUE_DEPTH entries (tag plus signed 64-bit priority) in arrival
// order in a chain of cells. Each accepted request launches a wave that passes
// one cell per clock, doing the tag search, the append at the first free cell,
// the gap closing after a remove and the oldest or best-priority selection on
// its way. The next request can be accepted once the wave has walked through
// the chain and its result has moved from the pending result stage into the
// output register, which it does only while the output is free; that register
// drives m_tdata. One request is in work at a time; a finished result may
// wait in the output register while the next one runs.
// Only the low TAG_BITS bits of entry_tag are used (at most 16).
module dual_order_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode, entry_tag, priority_req
    input  logic [dopq_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found, result_tag, result_priority, status
    output logic [dopq_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import dopq_pkg::*;

    localparam int TW = (TAG_BITS < PORT_TAG_BITS) ? TAG_BITS : PORT_TAG_BITS;

    // wave links between cells, entry zero driven from the input channel
    wave_ctl_t                   ctl_w       [0:QUEUE_DEPTH];
    logic [TW-1:0]               tag_w       [0:QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] prio_w      [0:QUEUE_DEPTH];
    logic [TW-1:0]               btag_w      [0:QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] bprio_w     [0:QUEUE_DEPTH];
    logic                        cv_w        [0:QUEUE_DEPTH];
    logic [TW-1:0]               ct_w        [0:QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] cp_w        [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      valid_vec;
    logic [QUEUE_DEPTH-1:0]      act_vec;

    logic                        busy_reg, busy_next;
    logic                        pend_reg, pend_next;
    logic                        pend_found_reg, pend_found_next;
    logic [TW-1:0]               pend_tag_reg, pend_tag_next;
    logic signed [PRIO_BITS-1:0] pend_prio_reg, pend_prio_next;
    logic [STATUS_BITS-1:0]      pend_status_reg, pend_status_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0]    m_tdata_reg, m_tdata_next;

    logic s_accept;
    logic move;
    wave_ctl_t                   ex_ctl;
    wave_ctl_t                   launch_ctl;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = aresetn && !busy_reg;

    // launch the wave into the first cell
    always_comb begin
        launch_ctl.active  = s_accept;
        launch_ctl.mode    = s_tdata[IN_MODE_LSB +: MODE_BITS];
        launch_ctl.hit     = 1'b0;
        launch_ctl.placed  = 1'b0;
        launch_ctl.best_ok = 1'b0;
    end
    assign ctl_w[0]   = launch_ctl;
    assign tag_w[0]   = s_tdata[IN_TAG_LSB +: TW];
    assign prio_w[0]  = s_tdata[IN_PRIO_LSB +: PRIO_BITS];
    assign btag_w[0]  = '0;
    assign bprio_w[0] = '0;

    // the chain past the last cell is empty
    assign cv_w[QUEUE_DEPTH] = 1'b0;
    assign ct_w[QUEUE_DEPTH] = '0;
    assign cp_w[QUEUE_DEPTH] = '0;

    // cell chain
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        dopq_cell #(
            .TW (TW)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl_in        (ctl_w[gi]),
            .tag_in        (tag_w[gi]),
            .prio_in       (prio_w[gi]),
            .best_tag_in   (btag_w[gi]),
            .best_prio_in  (bprio_w[gi]),
            .nb_valid      (cv_w[gi+1]),
            .nb_tag        (ct_w[gi+1]),
            .nb_prio       (cp_w[gi+1]),
            .ctl_out       (ctl_w[gi+1]),
            .tag_out       (tag_w[gi+1]),
            .prio_out      (prio_w[gi+1]),
            .best_tag_out  (btag_w[gi+1]),
            .best_prio_out (bprio_w[gi+1]),
            .own_valid     (cv_w[gi]),
            .own_tag       (ct_w[gi]),
            .own_prio      (cp_w[gi])
        );
        assign valid_vec[gi] = cv_w[gi];
        assign act_vec[gi]   = ctl_w[gi+1].active;
    end

    assign ex_ctl = ctl_w[QUEUE_DEPTH];
    assign move   = pend_reg && (!m_tvalid_reg || m_tready);

    // result of the wave leaving the chain
    always_comb begin
        pend_next        = pend_reg;
        pend_found_next  = pend_found_reg;
        pend_tag_next    = pend_tag_reg;
        pend_prio_next   = pend_prio_reg;
        pend_status_next = pend_status_reg;
        if (move) begin
            pend_next = 1'b0;
        end
        if (ex_ctl.active) begin
            pend_next        = 1'b1;
            pend_found_next  = 1'b0;
            pend_status_next = ST_OK;
            unique case (ex_ctl.mode)
                MODE_ENQ: begin
                    if (ex_ctl.hit) begin
                        pend_status_next = ST_DUP;
                    end else if (!ex_ctl.placed) begin
                        pend_status_next = ST_FULL;
                    end
                end
                MODE_REMOVE: begin
                    if (!ex_ctl.hit) begin
                        pend_status_next = ST_ABSENT;
                    end
                end
                MODE_OLDEST: begin
                    pend_found_next = ex_ctl.best_ok;
                end
                MODE_BEST: begin
                    pend_found_next = ex_ctl.best_ok &&
                                      !(prio_w[QUEUE_DEPTH] < bprio_w[QUEUE_DEPTH]);
                end
            endcase
            pend_tag_next  = pend_found_next ? btag_w[QUEUE_DEPTH] : '0;
            pend_prio_next = pend_found_next ? bprio_w[QUEUE_DEPTH] : '0;
        end
    end

    // output register and busy flag
    always_comb begin
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (move) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[OUT_FOUND_LSB]                    = pend_found_reg;
            m_tdata_next[OUT_TAG_LSB +: PORT_TAG_BITS]     = PORT_TAG_BITS'(pend_tag_reg);
            m_tdata_next[OUT_PRIO_LSB +: PRIO_BITS]        = pend_prio_reg;
            m_tdata_next[OUT_STATUS_LSB +: STATUS_BITS]    = pend_status_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_found_reg  <= pend_found_next;
        pend_tag_reg    <= pend_tag_next;
        pend_prio_reg   <= pend_prio_next;
        pend_status_reg <= pend_status_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // an idle block has no wave in the chain and no pending result
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (act_vec == '0 && !pend_reg))
        else $error("wave or pending result while idle");

    // at most one wave in the chain
    a_one_wave: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(act_vec))
        else $error("more than one request wave in the chain");

    // stored entries always form a prefix of the chain
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in the stored entries");

    // a found entry always comes with an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[OUT_FOUND_LSB]) |->
        (m_tdata_reg[OUT_STATUS_LSB +: STATUS_BITS] == ST_OK))
        else $error("found entry with error status");
`endif

endmodule
